// ===== rtl/core/rpfe_pkg.sv =====
// Shared constants, codes and color helpers for the RGB palette fade engine.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package rpfe_pkg;

    localparam int PALETTE_DEPTH = 8;
    localparam int COLUMNS       = 16;

    localparam int PAL_AW  = 3;   // palette position / load address width
    localparam int COL_AW  = 4;   // column ring address width
    localparam int CHAN_W  = 8;
    localparam int RGB_W   = 3 * CHAN_W;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 8;

    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [RGB_W-1:0]  t_rgb;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_LOAD = 2'd1,
        OP_READ = 2'd2
    } t_op;

    typedef enum logic [CFG_AW-1:0] {
        CFG_STEP_INTERVAL = 2'd0,
        CFG_STEP_SIZE     = 2'd1,
        CFG_COLORS_IN_USE = 2'd2
    } t_cfg_idx;

    // Raw palette byte b maps to (255*b) mod 256, i.e. the two's complement of b.
    function automatic t_chan scale_chan(input t_chan raw);
        scale_chan = t_chan'(~raw + 1'b1);
    endfunction

    function automatic t_rgb scale_rgb(input t_rgb raw);
        scale_rgb = {scale_chan(raw[23:16]), scale_chan(raw[15:8]), scale_chan(raw[7:0])};
    endfunction

    // Move cur toward tgt by step, landing on tgt instead of passing it.
    function automatic t_chan approach(input t_chan cur, input t_chan tgt, input t_chan step);
        logic [CHAN_W:0] up;
        logic [CHAN_W:0] lim;
        up  = {1'b0, cur} + {1'b0, step};
        lim = {1'b0, tgt} + {1'b0, step};
        if (cur < tgt) begin
            approach = (up < {1'b0, tgt}) ? up[CHAN_W-1:0] : tgt;
        end else if (cur > tgt) begin
            approach = ({1'b0, cur} > lim) ? t_chan'(cur - step) : tgt;
        end else begin
            approach = cur;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rpfe_in_if.sv =====
// Input channel of the palette fade engine: valid/ready plus one request.
// Depends on rpfe_pkg for field widths.
`default_nettype none

interface rpfe_in_if;
    import rpfe_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [3:0]        index;
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;

    modport source (
        output valid, operation, index, in_red, in_green, in_blue,
        input  ready
    );

    modport sink (
        input  valid, operation, index, in_red, in_green, in_blue,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/rpfe_out_if.sv =====
// Result channel of the palette fade engine: valid/ready plus one color result.
// Depends on rpfe_pkg for field widths.
`default_nettype none

interface rpfe_out_if;
    import rpfe_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic              stepped;

    modport source (
        output valid, out_red, out_green, out_blue, stepped,
        input  ready
    );

    modport sink (
        input  valid, out_red, out_green, out_blue, stepped,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/rgb_palette_fade_engine.sv =====
// Top level of the RGB palette fade engine.
// Depends on rpfe_pkg, rpfe_in_if and rpfe_out_if.
//
// Usage:
//   i_item carries requests: tick (prescaled fade step), palette load, or
//   column read. o_result returns exactly one transaction per request, in
//   order: the current color (tick, load, unused code) or the addressed
//   column's color (read), plus a stepped flag for ticks that ran a fade step.
//   Configuration (step interval, step size, colors in use) is written through
//   i_cfg_we / i_cfg_idx / i_cfg_data while no request is in flight.
//
//   Each request passes through the input register, then the fade logic into
//   the result register. Throughput: one request per cycle while the receiver
//   takes results; each request reads the state left by the one before it in
//   the same cycle it updates it.
//   When the receiver stalls, the result register holds, the input register
//   fills behind it, then i_item.ready drops. It rises again as soon as the
//   result is taken.
//   Reset (synchronous, active low) clears the pipeline, all fade state,
//   the palette and the column ring, and loads the register defaults.
`default_nettype none

module rgb_palette_fade_engine (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    rpfe_in_if.sink                  i_item,
    rpfe_out_if.source               o_result,
    input  wire                      i_cfg_we,
    input  wire [rpfe_pkg::CFG_AW-1:0] i_cfg_idx,
    input  wire [rpfe_pkg::CFG_DW-1:0] i_cfg_data
);
    import rpfe_pkg::*;

    // configuration
    logic [7:0] r_step_interval;
    logic [7:0] r_step_size;
    logic [3:0] r_colors_in_use;

    // input register
    logic        r_in_valid;
    logic [1:0]  r_in_op;
    logic [3:0]  r_in_idx;
    t_rgb        r_in_rgb;

    // result register
    logic        r_out_valid;
    t_rgb        r_out_rgb;
    logic        r_out_stepped;

    // fade state
    logic [7:0]        r_tick_count;
    logic [PAL_AW-1:0] r_pal_pos;
    t_rgb              r_current;
    t_rgb              r_target;
    logic [COL_AW-1:0] r_ring_pos;
    t_rgb              r_palette [PALETTE_DEPTH];
    logic [PALETTE_DEPTH-1:0] r_pal_vld;
    t_rgb              r_columns [COLUMNS];
    logic [COLUMNS-1:0] r_col_vld;

    logic              out_free;
    logic              fire;
    logic [7:0]        tick_inc;
    logic              step_fire;
    logic [PAL_AW-1:0] last_pos;
    logic [PAL_AW-1:0] n_pal_pos;
    logic [PAL_AW-1:0] next_pos;
    t_rgb              n_target;
    t_rgb              n_current;
    logic [COL_AW-1:0] n_ring_pos;
    t_rgb              col_rd;
    t_rgb              n_out_rgb;
    logic              is_tick;
    logic              is_load;

    assign out_free     = !r_out_valid || o_result.ready;
    assign fire         = r_in_valid && out_free;
    assign i_item.ready = !r_in_valid || out_free;

    assign o_result.valid     = r_out_valid;
    assign o_result.out_red   = r_out_rgb[23:16];
    assign o_result.out_green = r_out_rgb[15:8];
    assign o_result.out_blue  = r_out_rgb[7:0];
    assign o_result.stepped   = r_out_stepped;

    always_comb begin
        is_tick = 1'b0;
        is_load = 1'b0;
        case (r_in_op)
            OP_TICK: is_tick = 1'b1;
            OP_LOAD: is_load = 1'b1;
            default: ;
        endcase
    end

    // fade step datapath
    always_comb begin
        tick_inc  = r_tick_count + 8'd1;
        step_fire = is_tick && (tick_inc >= r_step_interval);

        // colors_in_use clamped to 1..PALETTE_DEPTH, minus one
        if (r_colors_in_use == 4'd0) begin
            last_pos = '0;
        end else if (r_colors_in_use > 4'(PALETTE_DEPTH)) begin
            last_pos = PAL_AW'(PALETTE_DEPTH - 1);
        end else begin
            last_pos = PAL_AW'(r_colors_in_use - 4'd1);
        end

        n_pal_pos = r_pal_pos;
        if (r_current == r_target) begin
            n_pal_pos = (r_pal_pos < last_pos) ? PAL_AW'(r_pal_pos + 1'b1) : '0;
        end
        next_pos = (n_pal_pos < last_pos) ? PAL_AW'(n_pal_pos + 1'b1) : '0;

        n_target  = r_pal_vld[next_pos] ? scale_rgb(r_palette[next_pos]) : '0;
        n_current = {approach(r_current[23:16], n_target[23:16], r_step_size),
                     approach(r_current[15:8],  n_target[15:8],  r_step_size),
                     approach(r_current[7:0],   n_target[7:0],   r_step_size)};

        n_ring_pos = (r_ring_pos == COL_AW'(COLUMNS - 1)) ? '0 : COL_AW'(r_ring_pos + 1'b1);
    end

    always_comb begin
        col_rd = r_col_vld[r_in_idx[COL_AW-1:0]] ? r_columns[r_in_idx[COL_AW-1:0]] : '0;
        case (r_in_op)
            OP_TICK: n_out_rgb = step_fire ? n_current : r_current;
            OP_READ: n_out_rgb = (5'(r_in_idx) < 5'(COLUMNS)) ? col_rd : '0;
            default: n_out_rgb = r_current;
        endcase
    end

    // control and fade state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_interval <= 8'd20;
            r_step_size     <= 8'd1;
            r_colors_in_use <= 4'd8;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_tick_count    <= '0;
            r_pal_pos       <= '0;
            r_current       <= '0;
            r_target        <= '0;
            r_ring_pos      <= '0;
            r_pal_vld       <= '0;
            r_col_vld       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_STEP_INTERVAL: r_step_interval <= i_cfg_data;
                    CFG_STEP_SIZE:     r_step_size     <= i_cfg_data;
                    CFG_COLORS_IN_USE: r_colors_in_use <= i_cfg_data[3:0];
                    default: ;
                endcase
            end

            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end

            if (fire && is_tick) begin
                r_tick_count <= step_fire ? 8'd0 : tick_inc;
                if (step_fire) begin
                    r_pal_pos  <= n_pal_pos;
                    r_target   <= n_target;
                    r_current  <= n_current;
                    r_ring_pos <= n_ring_pos;
                    r_col_vld[n_ring_pos] <= 1'b1;
                end
            end
            if (fire && is_load && (r_in_idx < 4'(PALETTE_DEPTH))) begin
                r_pal_vld[r_in_idx[PAL_AW-1:0]] <= 1'b1;
            end
        end
    end

    // payload registers and stores
    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in_op  <= i_item.operation;
            r_in_idx <= i_item.index;
            r_in_rgb <= {i_item.in_red, i_item.in_green, i_item.in_blue};
        end
        if (fire) begin
            r_out_rgb     <= n_out_rgb;
            r_out_stepped <= step_fire;
        end
        if (fire && step_fire) begin
            r_columns[n_ring_pos] <= n_current;
        end
        if (fire && is_load && (r_in_idx < 4'(PALETTE_DEPTH))) begin
            r_palette[r_in_idx[PAL_AW-1:0]] <= r_in_rgb;
        end
    end

    // a fade step restarts the prescaler
    a_step_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && step_fire) |=> (r_tick_count == 8'd0))
        else $error("prescaler not cleared after fade step");

    // the ring only moves on a fade step
    a_ring_moves_on_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fire && step_fire) |=> $stable(r_ring_pos))
        else $error("ring position moved without a fade step");

    // a held request in the input register keeps its contents while blocked
    a_in_reg_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> (r_in_valid && $stable(r_in_op) && $stable(r_in_idx)))
        else $error("input register changed while blocked");

endmodule

`default_nettype wire

// ===== verif/rpfe_color_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the RGB palette fade engine: tracks register writes and requests,
// predicts each color result and compares it with the result channel.
// Depends on rpfe_pkg, rpfe_in_if and rpfe_out_if.

module rpfe_color_checker (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    rpfe_in_if                         i_item,
    rpfe_out_if                        i_result,
    input  wire                        i_cfg_we,
    input  wire [rpfe_pkg::CFG_AW-1:0] i_cfg_idx,
    input  wire [rpfe_pkg::CFG_DW-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);
    import rpfe_pkg::*;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
        logic  stepped;
    } t_fade_result;

    logic [7:0] interval_cfg = 8'd20;
    logic [7:0] size_cfg     = 8'd1;
    logic [3:0] colors_cfg   = 4'd8;

    logic [7:0] tick_cnt = '0;
    int         pal_pos  = 0;
    int         ring_pos = 0;
    t_rgb       cur_rgb  = '0;
    t_rgb       tgt_rgb  = '0;
    t_rgb       column_ring [COLUMNS];
    t_rgb       palette     [PALETTE_DEPTH];

    t_fade_result expected_colors [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Raw byte b shows up as (255 * b) mod 256.
    function automatic t_chan shade_of(input t_chan raw);
        return t_chan'((255 * int'(raw)) % 256);
    endfunction

    // Step toward the target, clamping on it rather than overshooting.
    function automatic t_chan move_toward(input t_chan cur, input t_chan tgt,
                                          input logic [7:0] step);
        int c, t, s;
        c = int'(cur);
        t = int'(tgt);
        s = int'(step);
        if (c < t) return (c + s < t) ? t_chan'(c + s) : tgt;
        if (c > t) return (c > t + s) ? t_chan'(c - s) : tgt;
        return cur;
    endfunction

    function automatic void run_fade_step();
        int   used;
        int   nxt;
        t_rgb raw;
        used = int'(colors_cfg);
        if (used < 1) used = 1;
        if (used > PALETTE_DEPTH) used = PALETTE_DEPTH;
        if (cur_rgb == tgt_rgb) pal_pos = (pal_pos < used - 1) ? pal_pos + 1 : 0;
        nxt = (pal_pos < used - 1) ? pal_pos + 1 : 0;
        raw = palette[nxt];
        tgt_rgb = {shade_of(raw[23:16]), shade_of(raw[15:8]), shade_of(raw[7:0])};
        cur_rgb = {move_toward(cur_rgb[23:16], tgt_rgb[23:16], size_cfg),
                   move_toward(cur_rgb[15:8],  tgt_rgb[15:8],  size_cfg),
                   move_toward(cur_rgb[7:0],   tgt_rgb[7:0],   size_cfg)};
        ring_pos = (ring_pos + 1) % COLUMNS;
        column_ring[ring_pos] = cur_rgb;
    endfunction

    function automatic t_fade_result predict_color(input logic [1:0] op,
                                                   input logic [3:0] idx,
                                                   input t_chan r, input t_chan g,
                                                   input t_chan b);
        t_rgb color;
        logic ran;
        color = cur_rgb;
        ran   = 1'b0;
        case (op)
            OP_TICK: begin
                tick_cnt = tick_cnt + 8'd1;
                if (tick_cnt >= interval_cfg) begin
                    tick_cnt = '0;
                    run_fade_step();
                    ran = 1'b1;
                end
                color = cur_rgb;
            end
            OP_LOAD: begin
                // entries past the palette depth are dropped
                if (idx < PALETTE_DEPTH) palette[idx[PAL_AW-1:0]] = {r, g, b};
            end
            OP_READ: begin
                color = (idx < COLUMNS) ? column_ring[idx] : '0;
            end
            default: ;
        endcase
        return '{red: color[23:16], green: color[15:8], blue: color[7:0], stepped: ran};
    endfunction

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_fade_result want;
        if (!i_rst_n) begin
            interval_cfg = 8'd20;
            size_cfg     = 8'd1;
            colors_cfg   = 4'd8;
            tick_cnt     = '0;
            pal_pos      = 0;
            ring_pos     = 0;
            cur_rgb      = '0;
            tgt_rgb      = '0;
            foreach (column_ring[k]) column_ring[k] = '0;
            foreach (palette[k]) palette[k] = '0;
            expected_colors.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                if (expected_colors.size() == 0) begin
                    $display("%0t ns: unexpected result transaction, got %h %h %h stepped %b",
                             $time, i_result.out_red, i_result.out_green,
                             i_result.out_blue, i_result.stepped);
                    o_fail_count++;
                end else begin
                    want = expected_colors.pop_front();
                    check_field("out_red",   want.red,   i_result.out_red);
                    check_field("out_green", want.green, i_result.out_green);
                    check_field("out_blue",  want.blue,  i_result.out_blue);
                    check_field("stepped",   {7'd0, want.stepped}, {7'd0, i_result.stepped});
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_STEP_INTERVAL: interval_cfg = i_cfg_data;
                    CFG_STEP_SIZE:     size_cfg     = i_cfg_data;
                    CFG_COLORS_IN_USE: colors_cfg   = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_item.valid && i_item.ready) begin
                expected_colors.push_back(predict_color(i_item.operation, i_item.index,
                                                        i_item.in_red, i_item.in_green,
                                                        i_item.in_blue));
            end
        end
        o_pending = expected_colors.size();
    end

endmodule

// ===== verif/rgb_palette_fade_engine_test.sv =====
`timescale 1ns / 1ps
// Top of the palette fade engine testbench: clock, reset, register writes, requests
// and result back-pressure. Depends on rpfe_pkg, the channel interfaces and rpfe_color_checker.

module rgb_palette_fade_engine_test;
    import rpfe_pkg::*;

    localparam int         STALL_LIMIT = 3000;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_AW-1:0] i_cfg_idx = '0;
    logic [CFG_DW-1:0] i_cfg_data = '0;

    int fail_count;
    int pending_count;
    bit hold_request = 1'b0;

    rpfe_in_if  req_ch ();
    rpfe_out_if res_ch ();

    always #1 i_clk = ~i_clk;

    rgb_palette_fade_engine dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (req_ch),
        .o_result   (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    rpfe_color_checker u_color_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (req_ch),
        .i_result     (res_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_chan any_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h01;
            3: return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    // Offer one request and hold it until the engine takes it.
    task automatic send_req(input logic [1:0] op, input logic [3:0] idx, input t_chan r,
                            input t_chan g, input t_chan b, input int gap);
        @(negedge i_clk);
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.index     <= idx;
        req_ch.in_red    <= r;
        req_ch.in_green  <= g;
        req_ch.in_blue   <= b;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        if (gap > 0) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_random(input int gap);
        int         r;
        logic [1:0] op;
        logic [3:0] idx;
        r   = $urandom_range(0, 99);
        idx = 4'($urandom_range(0, 15));
        if (r < 65) begin
            op = OP_TICK;
        end else if (r < 80) begin
            op = OP_LOAD;
            // mostly real palette slots, sometimes out of range
            if ($urandom_range(0, 4) != 0) idx = {1'b0, 3'($urandom_range(0, 7))};
        end else if (r < 97) begin
            op = OP_READ;
        end else begin
            op = OP_UNUSED;
        end
        send_req(op, idx, any_byte(), any_byte(), any_byte(), gap);
    endtask

    // Drop valid and wait until every outstanding transaction has come back.
    task automatic settle();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DW-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] interval, input logic [7:0] size,
                             input logic [7:0] colors, input int count, input bit squeeze);
        bit burst;
        int k;
        settle();
        cfg_write(CFG_STEP_INTERVAL, interval);
        cfg_write(CFG_STEP_SIZE, size);
        cfg_write(CFG_COLORS_IN_USE, colors);
        if (squeeze) hold_request = 1'b1;
        burst = squeeze;
        for (k = 0; k < count; k++) begin
            if (k % 40 == 0 && !(squeeze && k < 80)) burst = ($urandom_range(0, 2) == 0);
            send_random(burst ? 0 : pick_gap());
        end
    endtask

    // Result side back-pressure; a requested hold keeps ready low long enough to fill the engine.
    initial begin : result_sink
        bit ready_val;
        int span;
        int r;
        res_ch.ready = 1'b0;
        forever begin
            if (hold_request) begin
                ready_val    = 1'b0;
                span         = 120;
                hold_request = 1'b0;
            end else begin
                r = $urandom_range(0, 9);
                if (r < 3) begin
                    ready_val = 1'b1;
                    span      = $urandom_range(20, 60);
                end else if (r < 7) begin
                    ready_val = 1'b1;
                    span      = $urandom_range(1, 4);
                end else if (r < 9) begin
                    ready_val = 1'b0;
                    span      = $urandom_range(1, 3);
                end else begin
                    ready_val = 1'b0;
                    span      = $urandom_range(8, 30);
                end
            end
            @(negedge i_clk);
            res_ch.ready <= ready_val;
            repeat (span - 1) @(negedge i_clk);
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_TICK;
        req_ch.index     = '0;
        req_ch.in_red    = '0;
        req_ch.in_green  = '0;
        req_ch.in_blue   = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: fast full-size steps over a two-color palette.
        cfg_write(CFG_STEP_INTERVAL, 8'd0);
        cfg_write(CFG_STEP_SIZE, 8'd255);
        cfg_write(CFG_COLORS_IN_USE, 8'd2);
        send_req(OP_LOAD, 4'd0, 8'hFF, 8'h01, 8'h80, 0);
        send_req(OP_LOAD, 4'd1, 8'h00, 8'hFF, 8'h7F, 0);
        send_req(OP_LOAD, 4'd7, 8'h01, 8'h00, 8'hFF, 1);
        send_req(OP_LOAD, 4'd8, 8'hAA, 8'h55, 8'hAA, 0);   // past palette depth: dropped
        send_req(OP_LOAD, 4'd15, 8'hFF, 8'hFF, 8'hFF, 0);
        send_req(OP_UNUSED, 4'd15, 8'hFF, 8'hFF, 8'hFF, 0);
        repeat (8) send_req(OP_TICK, 4'd0, 8'h00, 8'h00, 8'h00, 0);
        send_req(OP_READ, 4'd0, 8'h00, 8'h00, 8'h00, 0);
        send_req(OP_READ, 4'd1, 8'h00, 8'h00, 8'h00, 2);
        send_req(OP_READ, 4'd15, 8'h00, 8'h00, 8'h00, 0);
        send_req(OP_READ, 4'd8, 8'h00, 8'h00, 8'h00, 0);
        send_req(OP_LOAD, 4'd1, 8'h80, 8'h80, 8'h80, 0);
        repeat (4) send_req(OP_TICK, 4'd15, 8'hFF, 8'hFF, 8'hFF, 0);
        send_req(OP_READ, 4'd2, 8'h00, 8'h00, 8'h00, 0);

        run_phase(8'd0, 8'd255, 8'h08, 250, 1'b1);
        run_phase(8'd1, 8'd0, 8'h03, 220, 1'b0);
        run_phase(8'd20, 8'd1, 8'h08, 250, 1'b0);
        run_phase(8'd255, 8'd3, 8'h0F, 150, 1'b0);
        run_phase(8'd2, 8'd37, 8'h10, 250, 1'b0);   // color count nibble of zero
        repeat (2) begin
            run_phase(8'($urandom_range(0, 4)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 180, 1'b0);
        end

        settle();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
